// ----- hdl/dtd_pkg.sv -----
// Shared types, constants and fixed-point helpers for the temperature drop detector.
`timescale 1ns / 1ps

package dtd_pkg;

    // Fixed-point formats
    localparam int STATE_FRAC_BITS = 24;
    localparam int REG_FRAC_BITS   = 24;
    localparam int STATE_W         = 40;
    localparam int DIFF_W          = STATE_W + 1;
    localparam int CMP_W           = STATE_W + 2;

    // Field and register widths
    localparam int TEMP_W     = 17;
    localparam int VOLT_W     = 13;
    localparam int DV_W       = VOLT_W + 1;
    localparam int KEEP_W     = 16;
    localparam int MARGIN_W   = 24;
    localparam int OFFSET_W   = 13;
    localparam int GAIN_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier: signed MUL_W x signed MUL_W
    localparam int MUL_W  = DIFF_W - KEEP_W;
    localparam int PROD_W = 2 * MUL_W;

    // Stream payloads
    localparam int IN_BITS     = 2 * TEMP_W + VOLT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // Smoother channels: chip slow, chip fast, ext slow, ext fast
    localparam int NUM_AVG = 4;
    localparam int CHAN_W  = 2;
    localparam logic [CHAN_W-1:0] CH_CHIP_SLOW = 2'd0;
    localparam logic [CHAN_W-1:0] CH_CHIP_FAST = 2'd1;
    localparam logic [CHAN_W-1:0] CH_EXT_SLOW  = 2'd2;
    localparam logic [CHAN_W-1:0] CH_EXT_FAST  = 2'd3;
    localparam logic [CHAN_W-1:0] CH_LAST      = CHAN_W'(NUM_AVG - 1);

    // Chip sum has 8 fraction bits plus one more for the halving
    localparam int CHIP_SH = STATE_FRAC_BITS - 9;
    localparam int UP_SH   = (STATE_FRAC_BITS >= REG_FRAC_BITS) ?
                             (STATE_FRAC_BITS - REG_FRAC_BITS) : 0;
    localparam int DN_SH   = (STATE_FRAC_BITS < REG_FRAC_BITS) ?
                             (REG_FRAC_BITS - STATE_FRAC_BITS) : 0;

    localparam logic signed [63:0] STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
    localparam logic signed [63:0] STATE_MIN = -(64'sd1 <<< (STATE_W - 1));
    localparam logic signed [STATE_W-1:0] T25 = STATE_W'(64'sd25 <<< STATE_FRAC_BITS);

    // Register reset values
    localparam logic [KEEP_W-1:0]   RST_SLOW_KEEP   = 16'd65470;
    localparam logic [KEEP_W-1:0]   RST_FAST_KEEP   = 16'd58982;
    localparam logic [MARGIN_W-1:0] RST_RISE_MARGIN = 24'd167772;
    localparam logic [MARGIN_W-1:0] RST_FALL_MARGIN = 24'd1677722;
    localparam logic [OFFSET_W-1:0] RST_EXT_OFFSET  = 13'd600;
    localparam logic [GAIN_W-1:0]   RST_EXT_GAIN    = 24'd1677722;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_KEEP   = 3'd0,
        CFG_FAST_KEEP   = 3'd1,
        CFG_RISE_MARGIN = 3'd2,
        CFG_FALL_MARGIN = 3'd3,
        CFG_EXT_OFFSET  = 3'd4,
        CFG_EXT_GAIN    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [KEEP_W-1:0]   slow_keep;
        logic [KEEP_W-1:0]   fast_keep;
        logic [MARGIN_W-1:0] rise_margin;
        logic [MARGIN_W-1:0] fall_margin;
        logic [OFFSET_W-1:0] ext_offset_mv;
        logic [GAIN_W-1:0]   ext_gain;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic              ext_mul;
        logic              ext_conv;
        logic              sm_diff;
        logic              sm_lo;
        logic              sm_hi;
        logic              sm_add;
        logic              finish;
        logic [CHAN_W-1:0] chan;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [63:0] v);
        if (v > STATE_MAX) begin
            return STATE_MAX[STATE_W-1:0];
        end else if (v < STATE_MIN) begin
            return STATE_MIN[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

    // 24 fraction bits to state format; right shift floors
    function automatic logic signed [63:0] reg_to_state(input logic signed [63:0] v);
        return (v <<< UP_SH) >>> DN_SH;
    endfunction

endpackage

// ----- hdl/dual_rate_temperature_drop_detector_top.sv -----
// Top level of the dual-rate temperature drop detector.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | chip_temp_a, chip_temp_b, volt
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | ext_green, chip_green
//  cfg       | in        | i_cfg_wr_en                   | i_cfg_index, i_cfg_data
//
// Each request runs in steps from acceptance to the result in the output register:
// one 25x25 multiplier is shared by the voltage conversion (multiply, then convert) and
// the four smoothers (difference, low product, high product, add), then hysteresis.
// The next request is accepted only once the sequencer is back in idle, so requests do
// not overlap; a waiting result stalls the sequence only in its last step, when the
// output register is still full.
// Reset is synchronous; the smoothers restart at 25.0 C and both indicators at green.
`timescale 1ns / 1ps

module dual_rate_temperature_drop_detector_top import dtd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [16:0] chip_temp_a, [33:17] chip_temp_b, [46:34] ext_voltage_mv, [47] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] ext_green, [1] chip_green, [7:2] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    dtd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dtd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg       (w_cfg),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ----- hdl/dtd_cfg.sv -----
// Configuration register file of the temperature drop detector.
`timescale 1ns / 1ps

module dtd_cfg import dtd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_keep     <= RST_SLOW_KEEP;
            r_cfg.fast_keep     <= RST_FAST_KEEP;
            r_cfg.rise_margin   <= RST_RISE_MARGIN;
            r_cfg.fall_margin   <= RST_FALL_MARGIN;
            r_cfg.ext_offset_mv <= RST_EXT_OFFSET;
            r_cfg.ext_gain      <= RST_EXT_GAIN;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SLOW_KEEP:   r_cfg.slow_keep     <= i_cfg_data[KEEP_W-1:0];
                CFG_FAST_KEEP:   r_cfg.fast_keep     <= i_cfg_data[KEEP_W-1:0];
                CFG_RISE_MARGIN: r_cfg.rise_margin   <= i_cfg_data[MARGIN_W-1:0];
                CFG_FALL_MARGIN: r_cfg.fall_margin   <= i_cfg_data[MARGIN_W-1:0];
                CFG_EXT_OFFSET:  r_cfg.ext_offset_mv <= i_cfg_data[OFFSET_W-1:0];
                CFG_EXT_GAIN:    r_cfg.ext_gain      <= i_cfg_data[GAIN_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/dtd_ctrl.sv -----
// Sequencer that steps the shared multiplier datapath through one request.
`timescale 1ns / 1ps

module dtd_ctrl import dtd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXT_MUL,
        S_EXT_CONV,
        S_DIFF,
        S_LO,
        S_HI,
        S_ADD,
        S_HYST
    } t_state;

    t_state            r_state;
    logic [CHAN_W-1:0] r_chan;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd      = '0;
        o_cmd.chan = r_chan;
        unique case (r_state)
            S_IDLE:     o_cmd.load     = i_in_valid;
            S_EXT_MUL:  o_cmd.ext_mul  = 1'b1;
            S_EXT_CONV: o_cmd.ext_conv = 1'b1;
            S_DIFF:     o_cmd.sm_diff  = 1'b1;
            S_LO:       o_cmd.sm_lo    = 1'b1;
            S_HI:       o_cmd.sm_hi    = 1'b1;
            S_ADD:      o_cmd.sm_add   = 1'b1;
            S_HYST:     o_cmd.finish   = i_status.out_free;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXT_MUL;
                    end
                end
                S_EXT_MUL:  r_state <= S_EXT_CONV;
                S_EXT_CONV: begin
                    r_state <= S_DIFF;
                    r_chan  <= '0;
                end
                S_DIFF:     r_state <= S_LO;
                S_LO:       r_state <= S_HI;
                S_HI:       r_state <= S_ADD;
                S_ADD: begin
                    r_chan <= r_chan + 1'b1;
                    if (r_chan == CH_LAST) begin
                        r_state <= S_HYST;
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_HYST: begin
                    // hold until the output register can take the result
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ----- hdl/dtd_dpath.sv -----
// Datapath: sample conversion, four smoothers on one multiplier, hysteresis, result register.
`timescale 1ns / 1ps

module dtd_dpath import dtd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  t_cfg                   i_cfg,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    logic signed [TEMP_W-1:0]  w_a;
    logic signed [TEMP_W-1:0]  w_b;
    logic        [VOLT_W-1:0]  w_v;
    logic signed [TEMP_W:0]    w_ab;
    logic signed [63:0]        w_chip_wide;
    logic signed [DV_W-1:0]    w_dv;
    logic signed [MUL_W-1:0]   w_mul_a;
    logic signed [MUL_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic        [KEEP_W-1:0]  w_keep;
    logic signed [STATE_W-1:0] w_x;
    logic signed [STATE_W-1:0] w_old;
    logic signed [CMP_W-1:0]   w_sum;
    logic signed [CMP_W-1:0]   w_up;
    logic signed [CMP_W-1:0]   w_dn;
    logic signed [CMP_W-1:0]   w_ext_d;
    logic signed [CMP_W-1:0]   w_chip_d;
    logic                      w_ext_green;
    logic                      w_chip_green;

    logic signed [STATE_W-1:0] r_chip_t;
    logic signed [STATE_W-1:0] r_ext_t;
    logic signed [DV_W-1:0]    r_dv;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [DIFF_W-1:0]  r_acc;
    logic signed [STATE_W-1:0] r_avg [NUM_AVG];
    logic                      r_ext_green;
    logic                      r_chip_green;
    logic                      r_out_valid;
    logic [1:0]                r_out_bits;

    assign w_a = i_in_data[TEMP_W-1:0];
    assign w_b = i_in_data[2*TEMP_W-1:TEMP_W];
    assign w_v = i_in_data[2*TEMP_W+VOLT_W-1:2*TEMP_W];

    assign w_ab        = (TEMP_W+1)'(w_a) + (TEMP_W+1)'(w_b);
    assign w_chip_wide = 64'(w_ab) <<< CHIP_SH;
    assign w_dv        = $signed({1'b0, w_v}) - $signed({1'b0, i_cfg.ext_offset_mv});

    // Smoother operands: x is the channel's sample, keep its weight
    assign w_keep = i_cmd.chan[0] ? i_cfg.fast_keep : i_cfg.slow_keep;
    assign w_x    = i_cmd.chan[1] ? r_ext_t : r_chip_t;
    assign w_old  = r_avg[i_cmd.chan];

    // new = x + hi(d)*keep + floor(lo(d)*keep / 2^16), d = old - x
    always_comb begin
        if (i_cmd.ext_mul) begin
            w_mul_a = MUL_W'(r_dv);
            w_mul_b = $signed(MUL_W'(i_cfg.ext_gain));
        end else if (i_cmd.sm_lo) begin
            w_mul_a = $signed(MUL_W'(r_diff[KEEP_W-1:0]));
            w_mul_b = $signed(MUL_W'(w_keep));
        end else begin
            w_mul_a = r_diff[DIFF_W-1:KEEP_W];
            w_mul_b = $signed(MUL_W'(w_keep));
        end
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_sum  = CMP_W'(r_acc) + CMP_W'(r_prod);

    // Hysteresis on both channels; the red test wins
    assign w_up     = CMP_W'(reg_to_state(64'(i_cfg.rise_margin)));
    assign w_dn     = CMP_W'(reg_to_state(64'(i_cfg.fall_margin)));
    assign w_ext_d  = CMP_W'(r_avg[CH_EXT_FAST]) - CMP_W'(r_avg[CH_EXT_SLOW]);
    assign w_chip_d = CMP_W'(r_avg[CH_CHIP_FAST]) - CMP_W'(r_avg[CH_CHIP_SLOW]);

    always_comb begin
        priority if (w_ext_d > w_up) begin
            w_ext_green = 1'b0;
        end else if (w_ext_d < -w_dn) begin
            w_ext_green = 1'b1;
        end else begin
            w_ext_green = r_ext_green;
        end
        priority if (w_chip_d > w_up) begin
            w_chip_green = 1'b0;
        end else if (w_chip_d < -w_dn) begin
            w_chip_green = 1'b1;
        end else begin
            w_chip_green = r_chip_green;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_chip_t <= sat_state(w_chip_wide);
            r_dv     <= w_dv;
        end
        if (i_cmd.ext_mul || i_cmd.sm_lo || i_cmd.sm_hi) begin
            r_prod <= w_prod;
        end
        if (i_cmd.ext_conv) begin
            r_ext_t <= sat_state(reg_to_state(64'(r_prod)));
        end
        if (i_cmd.sm_diff) begin
            r_diff <= DIFF_W'(w_old) - DIFF_W'(w_x);
        end
        if (i_cmd.sm_hi) begin
            // low partial product is never negative
            r_acc <= DIFF_W'(w_x) + DIFF_W'(r_prod >>> KEEP_W);
        end
        if (i_cmd.finish) begin
            r_out_bits <= {w_chip_green, w_ext_green};
        end
    end

    // Smoother state, indicators and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AVG; i++) begin
                r_avg[i] <= T25;
            end
            r_ext_green  <= 1'b1;
            r_chip_green <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.sm_add) begin
                r_avg[i_cmd.chan] <= sat_state(64'(w_sum));
            end
            if (i_cmd.finish) begin
                r_ext_green  <= w_ext_green;
                r_chip_green <= w_chip_green;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = {(OUT_TDATA_W-2)'(0), r_out_bits};

endmodule

// ----- hdl/dtd_checker.sv -----
// Port-level checks of the temperature drop detector, bound to the top level.
`timescale 1ns / 1ps

module dtd_checker import dtd_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted on consecutive cycles");

    // A new result only comes out of a running sequence
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind dual_rate_temperature_drop_detector_top dtd_checker u_dtd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
